[rtl/bcd_pkg.sv]
// Shared types and constants of the block cache directory.
// No dependencies; the interfaces, the core and the testbench use it.
package bcd_pkg;

	localparam int ENTRIES_DEF    = 128;
	localparam int BLOCK_BITS_DEF = 48;
	localparam int IDX_W          = 7;
	localparam int TIME_W         = 32;
	localparam int DEV_W          = 8;
	localparam int CNT_W          = 9;

	typedef enum logic [2:0] {
		F_LOOKUP_RD = 3'd0,
		F_LOOKUP_WR = 3'd1,
		F_FILL_DONE = 3'd2,
		F_SCHEDULE  = 3'd3,
		F_XFER_DONE = 3'd4,
		F_EVICT     = 3'd5
	} func_t;

	typedef enum logic [2:0] {
		C_FREE       = 3'd0,
		C_PEND_READ  = 3'd1,
		C_READING    = 3'd2,
		C_PEND_WRITE = 3'd3,
		C_WRITING    = 3'd4,
		C_IDLE       = 3'd5,
		C_USER_FILL  = 3'd6
	} cond_t;

	typedef enum logic [2:0] {
		S_HIT     = 3'd0,
		S_ALLOC   = 3'd1,
		S_FULL    = 3'd2,
		S_BUSY    = 3'd3,
		S_DONE    = 3'd4,
		S_NOTHING = 3'd5,
		S_ERROR   = 3'd6
	} status_t;

endpackage

[rtl/bcd_in_if.sv]
// Command channel of the block cache directory.
// Depends on bcd_pkg for field widths.
interface bcd_in_if #(parameter int BLOCK_BITS = bcd_pkg::BLOCK_BITS_DEF);
	logic                       valid;
	logic                       ready;
	logic [2:0]                 func;
	logic [bcd_pkg::DEV_W-1:0]  device;
	logic [BLOCK_BITS-1:0]      block_number;
	logic [bcd_pkg::CNT_W-1:0]  block_count;
	logic [bcd_pkg::IDX_W-1:0]  entry_index;
	logic [bcd_pkg::TIME_W-1:0] now;
	logic                       device_accepted;

	modport source (output valid, func, device, block_number, block_count, entry_index,
		now, device_accepted, input ready);
	modport sink (input valid, func, device, block_number, block_count, entry_index,
		now, device_accepted, output ready);
endinterface

[rtl/bcd_out_if.sv]
// Result channel of the block cache directory.
// Depends on bcd_pkg for field widths.
interface bcd_out_if #(parameter int BLOCK_BITS = bcd_pkg::BLOCK_BITS_DEF);
	logic                      valid;
	logic                      ready;
	logic [2:0]                status;
	logic [bcd_pkg::IDX_W-1:0] index;
	logic [2:0]                entry_condition;
	logic                      io_is_write;
	logic [bcd_pkg::DEV_W-1:0] io_device;
	logic [BLOCK_BITS-1:0]     io_block;

	modport source (output valid, status, index, entry_condition, io_is_write, io_device,
		io_block, input ready);
	modport sink (input valid, status, index, entry_condition, io_is_write, io_device,
		io_block, output ready);
endinterface

[rtl/bcd_ram.sv]
// Generic simple dual-port RAM with registered read.
// No dependencies.
module bcd_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic                 re,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

[rtl/block_cache_directory_core.sv]
// Top level of the block cache directory: sequencer, scan logic and result register.
// Depends on bcd_pkg, bcd_in_if, bcd_out_if and bcd_ram.
//
// Usage: commands arrive as items on the "in" channel and each one produces exactly
// one result item on the "out" channel. An item is taken when valid and ready are
// both high. All entry fields live in one RAM word, so every scanning command walks the
// RAM through its single read port, one entry per cycle.
// Lookup, schedule, transfer complete and evict oldest read every entry in turn,
// wait for the registered read of the last entry, then decide, write back and load
// the result. Fill done reads only the named entry before that final step, and an
// unknown command goes straight to it. The block takes one command at a time and
// accepts the next one only once it is back in idle.
// After reset the block sweeps the RAM to mark every entry free; ready stays low
// until the sweep is done.
// The result sits in an output register. A new command is accepted while an old
// result still waits; if the receiver stalls, the next command holds in its final
// step until the output register is free, and nothing is lost.
module block_cache_directory_core #(
	parameter int ENTRIES    = bcd_pkg::ENTRIES_DEF,
	parameter int BLOCK_BITS = bcd_pkg::BLOCK_BITS_DEF
) (
	input logic  clk,
	input logic  arst_n,
	bcd_in_if.sink   in,
	bcd_out_if.source out
);
	import bcd_pkg::*;

	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int WW = 3 + DEV_W + BLOCK_BITS + TIME_W;

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_SCAN  = 5'b00100,
		ST_FILL  = 5'b01000,
		ST_FIN   = 5'b10000
	} state_t;

	state_t state_q;

	// Latched command.
	logic [2:0]            func_q;
	logic [DEV_W-1:0]      dev_q;
	logic [BLOCK_BITS-1:0] blk_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [IDX_W-1:0]      eidx_q;
	logic [TIME_W-1:0]     now_q;
	logic                  acc_q;

	// Scan counters.
	logic [CW-1:0] issue_q;
	logic          vld_s1;
	logic [IW-1:0] idx_s1;
	logic [IW-1:0] clr_q;

	// Scan findings.
	logic          free_v_q, hit_v_q, old_v_q, r_v_q, w_v_q, bad_v_q;
	logic [IW-1:0] free_idx_q, hit_idx_q, old_idx_q, r_idx_q, w_idx_q, bad_idx_q;
	logic [WW-1:0] hit_word_q, r_word_q, w_word_q;
	logic [TIME_W-1:0] old_t_q;
	cond_t         bad_st_q;

	// Result register.
	logic                  out_valid_q;
	status_t               out_status_q;
	logic [IDX_W-1:0]      out_index_q;
	cond_t                 out_cond_q;
	logic                  out_wr_q;
	logic [DEV_W-1:0]      out_dev_q;
	logic [BLOCK_BITS-1:0] out_blk_q;

	// RAM ports.
	logic          ram_we, ram_re;
	logic [IW-1:0] ram_waddr, ram_raddr;
	logic [WW-1:0] ram_wdata, ram_rdata;

	bcd_ram #(.W(WW), .D(ENTRIES)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	function automatic logic [WW-1:0] pack(cond_t st, logic [DEV_W-1:0] dv,
		logic [BLOCK_BITS-1:0] bk, logic [TIME_W-1:0] tm);
		return {st, dv, bk, tm};
	endfunction

	// Fields of the word just read.
	cond_t                 rd_st;
	logic [DEV_W-1:0]      rd_dev;
	logic [BLOCK_BITS-1:0] rd_blk;
	logic [TIME_W-1:0]     rd_time;
	logic [BLOCK_BITS-1:0] rd_diff;
	logic                  rd_match, rd_in_range, rd_older;

	assign rd_st       = cond_t'(ram_rdata[WW-1 -: 3]);
	assign rd_dev      = ram_rdata[WW-4 -: DEV_W];
	assign rd_blk      = ram_rdata[TIME_W +: BLOCK_BITS];
	assign rd_time     = ram_rdata[TIME_W-1:0];
	assign rd_match    = (rd_dev == dev_q) && (rd_blk == blk_q);
	assign rd_diff     = rd_blk - blk_q;
	assign rd_in_range = rd_diff < BLOCK_BITS'(cnt_q);
	assign rd_older    = !old_v_q || (rd_time < old_t_q);

	logic in_fire, fin_go, scan_last, scan_wb;
	assign in.ready  = (state_q == ST_IDLE);
	assign in_fire   = in.valid && in.ready;
	assign fin_go    = (state_q == ST_FIN) && (!out_valid_q || out.ready);
	assign scan_last = vld_s1 && (idx_s1 == IW'(ENTRIES - 1));
	// Transfer complete retires transferring entries as they stream past.
	assign scan_wb   = (state_q == ST_SCAN) && vld_s1 && (func_q == F_XFER_DONE) &&
		(rd_st != C_FREE) && (rd_dev == dev_q) && rd_in_range &&
		((rd_st == C_READING) || (rd_st == C_WRITING));

	// Final decision of a command.
	status_t               res_status;
	logic [IW-1:0]         res_idx;
	cond_t                 res_cond;
	logic                  res_wr;
	logic [DEV_W-1:0]      res_dev;
	logic [BLOCK_BITS-1:0] res_blk;
	logic                  fin_we;
	logic [IW-1:0]         fin_addr;
	logic [WW-1:0]         fin_data;
	logic                  eidx_ok;
	cond_t                 new_st;

	assign eidx_ok = ({{(IW + 1){1'b0}}, eidx_q} < (IW + IDX_W + 1)'(ENTRIES));

	always_comb begin
		res_status = S_NOTHING;
		res_idx    = '0;
		res_cond   = C_FREE;
		res_wr     = 1'b0;
		res_dev    = '0;
		res_blk    = '0;
		fin_we     = 1'b0;
		fin_addr   = '0;
		fin_data   = '0;
		new_st     = C_FREE;
		case (func_q)
			F_LOOKUP_RD, F_LOOKUP_WR: begin
				if (hit_v_q) begin
					new_st = cond_t'(hit_word_q[WW-1 -: 3]);
					res_status = S_HIT;
					if (func_q == F_LOOKUP_WR) begin
						if (new_st == C_IDLE) begin
							new_st = C_USER_FILL;
						end else begin
							res_status = S_BUSY;
						end
					end
					res_idx  = hit_idx_q;
					res_cond = new_st;
					fin_we   = 1'b1;
					fin_addr = hit_idx_q;
					fin_data = pack(new_st, dev_q, blk_q, now_q);
				end else if (free_v_q || old_v_q) begin
					new_st     = (func_q == F_LOOKUP_RD) ? C_PEND_READ : C_USER_FILL;
					res_status = S_ALLOC;
					res_idx    = free_v_q ? free_idx_q : old_idx_q;
					res_cond   = new_st;
					fin_we     = 1'b1;
					fin_addr   = res_idx;
					fin_data   = pack(new_st, dev_q, blk_q, now_q);
				end else begin
					res_status = S_FULL;
				end
			end
			F_FILL_DONE: begin
				if (eidx_ok && (rd_st == C_USER_FILL)) begin
					res_status = S_DONE;
					res_idx    = IW'(eidx_q);
					res_cond   = C_PEND_WRITE;
					fin_we     = 1'b1;
					fin_addr   = IW'(eidx_q);
					fin_data   = {C_PEND_WRITE, ram_rdata[WW-4:0]};
				end else begin
					res_status = S_ERROR;
				end
			end
			F_SCHEDULE: begin
				if (r_v_q || w_v_q) begin
					res_wr   = !r_v_q;
					res_idx  = r_v_q ? r_idx_q : w_idx_q;
					fin_data = r_v_q ? r_word_q : w_word_q;
					res_dev  = fin_data[WW-4 -: DEV_W];
					res_blk  = fin_data[TIME_W +: BLOCK_BITS];
					if (acc_q) begin
						new_st     = r_v_q ? C_READING : C_WRITING;
						res_status = S_DONE;
						fin_we     = 1'b1;
						fin_addr   = res_idx;
						fin_data   = {new_st, fin_data[WW-4:0]};
					end else begin
						new_st     = r_v_q ? C_PEND_READ : C_PEND_WRITE;
						res_status = S_BUSY;
					end
					res_cond = new_st;
				end
			end
			F_XFER_DONE: begin
				if (bad_v_q) begin
					res_status = S_ERROR;
					res_idx    = bad_idx_q;
					res_cond   = bad_st_q;
				end else begin
					res_status = S_DONE;
				end
			end
			F_EVICT: begin
				if (old_v_q) begin
					res_status = S_DONE;
					res_idx    = old_idx_q;
					fin_we     = 1'b1;
					fin_addr   = old_idx_q;
					fin_data   = '0;
				end
			end
			default: begin
				res_status = S_NOTHING;
			end
		endcase
	end

	// RAM port selection: scan or fill-done read; clearing sweep, scan write-back, or final write.
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = '0;
		if (state_q == ST_SCAN && issue_q < CW'(ENTRIES)) begin
			ram_re    = 1'b1;
			ram_raddr = issue_q[IW-1:0];
		end else if (state_q == ST_FILL) begin
			ram_re    = 1'b1;
			ram_raddr = IW'(eidx_q);
		end
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (scan_wb) begin
			ram_we    = 1'b1;
			ram_waddr = idx_s1;
			ram_wdata = {C_IDLE, ram_rdata[WW-4:0]};
		end else begin
			ram_we    = fin_go && fin_we;
			ram_waddr = fin_addr;
			ram_wdata = fin_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			issue_q     <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
			free_v_q    <= 1'b0;
			hit_v_q     <= 1'b0;
			old_v_q     <= 1'b0;
			r_v_q       <= 1'b0;
			w_v_q       <= 1'b0;
			bad_v_q     <= 1'b0;
		end else begin
			if (out_valid_q && out.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IW'(ENTRIES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						free_v_q <= 1'b0;
						hit_v_q  <= 1'b0;
						old_v_q  <= 1'b0;
						r_v_q    <= 1'b0;
						w_v_q    <= 1'b0;
						bad_v_q  <= 1'b0;
						issue_q  <= '0;
						vld_s1   <= 1'b0;
						if (in.func == F_FILL_DONE) begin
							state_q <= ST_FILL;
						end else if (in.func > F_EVICT) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					vld_s1 <= (issue_q < CW'(ENTRIES));
					if (issue_q < CW'(ENTRIES)) begin
						issue_q <= issue_q + 1'b1;
					end
					if (vld_s1) begin
						case (func_q)
							F_LOOKUP_RD, F_LOOKUP_WR: begin
								if (rd_st == C_FREE) begin
									free_v_q <= 1'b1;
								end else if (rd_match && !hit_v_q) begin
									hit_v_q <= 1'b1;
								end
								if (rd_st == C_IDLE && rd_older) begin
									old_v_q <= 1'b1;
								end
							end
							F_SCHEDULE: begin
								if (rd_st == C_PEND_READ) begin
									r_v_q <= 1'b1;
								end
								if (rd_st == C_PEND_WRITE) begin
									w_v_q <= 1'b1;
								end
							end
							F_XFER_DONE: begin
								if (rd_st != C_FREE && rd_dev == dev_q && rd_in_range &&
									rd_st != C_READING && rd_st != C_WRITING) begin
									bad_v_q <= 1'b1;
								end
							end
							F_EVICT: begin
								if (rd_st == C_IDLE && rd_older) begin
									old_v_q <= 1'b1;
								end
							end
							default: begin
							end
						endcase
					end
					if (scan_last) begin
						state_q <= ST_FIN;
					end
				end
				ST_FILL: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_go) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: command latch, scan captures and result.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			func_q <= in.func;
			dev_q  <= in.device;
			blk_q  <= in.block_number;
			cnt_q  <= in.block_count;
			eidx_q <= in.entry_index;
			now_q  <= in.now;
			acc_q  <= in.device_accepted;
		end
		idx_s1 <= issue_q[IW-1:0];
		if (state_q == ST_SCAN && vld_s1) begin
			if (rd_st == C_FREE) begin
				free_idx_q <= idx_s1;
			end
			if (rd_st != C_FREE && rd_match && !hit_v_q) begin
				hit_idx_q  <= idx_s1;
				hit_word_q <= ram_rdata;
			end
			if (rd_st == C_IDLE && rd_older) begin
				old_idx_q <= idx_s1;
				old_t_q   <= rd_time;
			end
			if (rd_st == C_PEND_READ && !r_v_q) begin
				r_idx_q  <= idx_s1;
				r_word_q <= ram_rdata;
			end
			if (rd_st == C_PEND_WRITE && !w_v_q) begin
				w_idx_q  <= idx_s1;
				w_word_q <= ram_rdata;
			end
			if (!bad_v_q) begin
				bad_idx_q <= idx_s1;
				bad_st_q  <= rd_st;
			end
		end
		if (fin_go) begin
			out_status_q <= res_status;
			out_index_q  <= IDX_W'(res_idx);
			out_cond_q   <= res_cond;
			out_wr_q     <= res_wr;
			out_dev_q    <= res_dev;
			out_blk_q    <= res_blk;
		end
	end

	assign out.valid           = out_valid_q;
	assign out.status          = out_status_q;
	assign out.index           = out_index_q;
	assign out.entry_condition = out_cond_q;
	assign out.io_is_write     = out_wr_q;
	assign out.io_device       = out_dev_q;
	assign out.io_block        = out_blk_q;

	// An accepted command always moves the sequencer out of idle in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q != ST_IDLE))
		else $error("sequencer idle right after accepting a command");

	// Scan write-back never collides with the read of the next entry.
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("RAM read and write at the same address");

	// A result is loaded only into an empty or draining output register.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_go && out_valid_q) |-> out.ready)
		else $error("result overwritten before it was taken");
endmodule

[test/block_cache_directory_core_test.sv]
// Self-checking testbench of the block cache directory core.
// Depends on bcd_pkg, bcd_in_if, bcd_out_if and the core with its RAM.
module block_cache_directory_core_test;
	import bcd_pkg::*;

	localparam int NENT    = ENTRIES_DEF;
	localparam int BB      = BLOCK_BITS_DEF;
	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		logic [2:0]        func;
		logic [DEV_W-1:0]  device;
		logic [BB-1:0]     block_number;
		logic [CNT_W-1:0]  block_count;
		logic [IDX_W-1:0]  entry_index;
		logic [TIME_W-1:0] now;
		logic              device_accepted;
	} cmd_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [IDX_W-1:0] index;
		logic [2:0]       cond;
		logic             is_write;
		logic [DEV_W-1:0] dev;
		logic [BB-1:0]    blk;
	} answer_t;

	// Directed rows: a command, whether its answer is typed in, and that answer.
	typedef struct {
		cmd_t    cmd;
		bit      fixed;
		answer_t ans;
	} row_t;

	logic clk;
	logic arst_n;

	bcd_in_if  #(.BLOCK_BITS(BB)) cmd_ch ();
	bcd_out_if #(.BLOCK_BITS(BB)) ans_ch ();

	block_cache_directory_core #(.ENTRIES(NENT), .BLOCK_BITS(BB)) u_dut (
		.clk(clk), .arst_n(arst_n), .in(cmd_ch.sink), .out(ans_ch.source)
	);

	// Directory mirror used to predict each answer.
	cond_t             dir_cond [NENT];
	logic [DEV_W-1:0]  dir_dev  [NENT];
	logic [BB-1:0]     dir_blk  [NENT];
	logic [TIME_W-1:0] dir_time [NENT];

	answer_t pending_answers[$];
	int      mismatches;
	int      idle_cycles;
	int      send_idle_pct;
	int      recv_stall_pct;
	bit      long_hold;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic answer_t mk(status_t s, int idx, cond_t c);
		answer_t a;
		a = '0;
		a.status = s;
		a.index  = idx[IDX_W-1:0];
		a.cond   = c;
		return a;
	endfunction

	function automatic int oldest_idle();
		int best;
		best = -1;
		for (int i = 0; i < NENT; i++)
			if (dir_cond[i] == C_IDLE && (best < 0 || dir_time[i] < dir_time[best]))
				best = i;
		return best;
	endfunction

	// Applies one command to the mirror and returns the answer the core must give.
	function automatic answer_t predict_directory(cmd_t c);
		answer_t a;
		int slot;
		int sel;
		int bad;
		bit wr;
		logic [BB-1:0] dist_blk;
		a = mk(S_NOTHING, 0, C_FREE);
		case (c.func)
			F_LOOKUP_RD, F_LOOKUP_WR: begin
				slot = -1;
				for (int i = 0; i < NENT; i++) begin
					if (dir_cond[i] == C_FREE) begin
						slot = i;
					end else if (dir_dev[i] == c.device && dir_blk[i] == c.block_number) begin
						dir_time[i] = c.now;
						if (c.func == F_LOOKUP_RD) begin
							return mk(S_HIT, i, dir_cond[i]);
						end else if (dir_cond[i] == C_IDLE) begin
							dir_cond[i] = C_USER_FILL;
							return mk(S_HIT, i, C_USER_FILL);
						end
						return mk(S_BUSY, i, dir_cond[i]);
					end
				end
				if (slot < 0) slot = oldest_idle();
				if (slot < 0) return mk(S_FULL, 0, C_FREE);
				dir_cond[slot] = (c.func == F_LOOKUP_RD) ? C_PEND_READ : C_USER_FILL;
				dir_dev[slot]  = c.device;
				dir_blk[slot]  = c.block_number;
				dir_time[slot] = c.now;
				a = mk(S_ALLOC, slot, dir_cond[slot]);
			end
			F_FILL_DONE: begin
				if (dir_cond[c.entry_index] == C_USER_FILL) begin
					dir_cond[c.entry_index] = C_PEND_WRITE;
					a = mk(S_DONE, c.entry_index, C_PEND_WRITE);
				end else begin
					a = mk(S_ERROR, 0, C_FREE);
				end
			end
			F_SCHEDULE: begin
				sel = -1;
				wr = 1'b0;
				for (int i = NENT - 1; i >= 0; i--)
					if (dir_cond[i] == C_PEND_READ) sel = i;
				if (sel < 0) begin
					wr = 1'b1;
					for (int i = NENT - 1; i >= 0; i--)
						if (dir_cond[i] == C_PEND_WRITE) sel = i;
				end
				if (sel >= 0) begin
					if (c.device_accepted) dir_cond[sel] = wr ? C_WRITING : C_READING;
					a = mk(c.device_accepted ? S_DONE : S_BUSY, sel, dir_cond[sel]);
					a.is_write = wr;
					a.dev = dir_dev[sel];
					a.blk = dir_blk[sel];
				end
			end
			F_XFER_DONE: begin
				bad = -1;
				for (int i = 0; i < NENT; i++) begin
					dist_blk = dir_blk[i] - c.block_number;
					if (dir_cond[i] != C_FREE && dir_dev[i] == c.device &&
					    dist_blk < BB'(c.block_count)) begin
						if (dir_cond[i] == C_READING || dir_cond[i] == C_WRITING)
							dir_cond[i] = C_IDLE;
						else if (bad < 0)
							bad = i;
					end
				end
				a = (bad >= 0) ? mk(S_ERROR, bad, dir_cond[bad]) : mk(S_DONE, 0, C_FREE);
			end
			F_EVICT: begin
				sel = oldest_idle();
				if (sel >= 0) begin
					dir_cond[sel] = C_FREE;
					a = mk(S_DONE, sel, C_FREE);
				end
			end
			default: ;
		endcase
		return a;
	endfunction

	// Sends one command, idling beforehand as the current phase asks. Valid stays
	// high after acceptance until the next command or a drain replaces it.
	task automatic send_cmd(cmd_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid           <= 1'b1;
		cmd_ch.func            <= c.func;
		cmd_ch.device          <= c.device;
		cmd_ch.block_number    <= c.block_number;
		cmd_ch.block_count     <= c.block_count;
		cmd_ch.entry_index     <= c.entry_index;
		cmd_ch.now             <= c.now;
		cmd_ch.device_accepted <= c.device_accepted;
		do @(posedge clk); while (!cmd_ch.ready);
	endtask

	task automatic send_checked(cmd_t c);
		pending_answers.push_back(predict_directory(c));
		send_cmd(c);
	endtask

	task automatic drain();
		cmd_ch.valid <= 1'b0;
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// Random command. A small pool of devices and blocks keeps hits and ranges common;
	// now is drawn from a narrow band so that ties in access time happen too.
	function automatic cmd_t rand_cmd();
		cmd_t c;
		int pick;
		c = '0;
		pick = $urandom_range(99);
		if (pick < 30)      c.func = F_LOOKUP_RD;
		else if (pick < 48) c.func = F_LOOKUP_WR;
		else if (pick < 60) c.func = F_FILL_DONE;
		else if (pick < 76) c.func = F_SCHEDULE;
		else if (pick < 88) c.func = F_XFER_DONE;
		else if (pick < 96) c.func = F_EVICT;
		else                c.func = 3'($urandom_range(7, 6));
		c.device = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(3));
		if ($urandom_range(9) == 0)
			c.block_number = {16'($urandom), 32'($urandom)};
		else
			c.block_number = 48'($urandom_range(40)) - 48'($urandom_range(1) * 20);
		c.block_count = ($urandom_range(9) == 0) ? 9'($urandom) : 9'($urandom_range(12));
		// Fill done names a random entry, or at times an entry in user fill when there is one.
		c.entry_index = 7'($urandom);
		for (int i = 0; i < NENT; i++)
			if (dir_cond[i] == C_USER_FILL && $urandom_range(3) == 0)
				c.entry_index = 7'(i);
		c.now = ($urandom_range(7) == 0) ? 32'($urandom) : 32'($urandom_range(15));
		c.device_accepted = ($urandom_range(3) != 0);
		return c;
	endfunction

	function automatic cmd_t cmd_of(func_t f, int dev, logic [BB-1:0] blk, int cnt,
			int eidx, logic [TIME_W-1:0] t, bit acc);
		cmd_t c;
		c.func = f;
		c.device = dev[DEV_W-1:0];
		c.block_number = blk;
		c.block_count = cnt[CNT_W-1:0];
		c.entry_index = eidx[IDX_W-1:0];
		c.now = t;
		c.device_accepted = acc;
		return c;
	endfunction

	// Receiver: random stalls, plus one long hold-off while commands keep coming.
	initial begin
		answer_t got;
		answer_t want;
		ans_ch.ready <= 1'b0;
		mismatches = 0;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				ans_ch.ready <= 1'b0;
				repeat (1500) @(posedge clk);
				long_hold = 1'b0;
			end
			ans_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			@(posedge clk);
			if (ans_ch.valid && ans_ch.ready) begin
				got = {ans_ch.status, ans_ch.index, ans_ch.entry_condition,
					ans_ch.io_is_write, ans_ch.io_device, ans_ch.io_block};
				if (pending_answers.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result item %h", got);
				end else begin
					want = pending_answers.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %h actual %h", want, got);
					end
				end
			end
		end
	end

	// Watchdog on cycles with no item moving on either channel.
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((cmd_ch.valid && cmd_ch.ready) || (ans_ch.valid && ans_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("block_cache_directory_core verification failed");
				$finish;
			end
		end
	end

	initial begin
		row_t rows[$];
		row_t r;
		long_hold = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (int i = 0; i < NENT; i++) dir_cond[i] = C_FREE;
		arst_n = 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.func <= F_LOOKUP_RD;
		cmd_ch.device <= '0;
		cmd_ch.block_number <= '0;
		cmd_ch.block_count <= '0;
		cmd_ch.entry_index <= '0;
		cmd_ch.now <= '0;
		cmd_ch.device_accepted <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table. Answers after reset and for error codes are typed in.
		rows = '{
			'{cmd_of(F_SCHEDULE, 0, 0, 1, 0, 0, 1), 1, mk(S_NOTHING, 0, C_FREE)},
			'{cmd_of(F_EVICT, 0, 0, 1, 0, 0, 0), 1, mk(S_NOTHING, 0, C_FREE)},
			'{cmd_of(F_FILL_DONE, 0, 0, 1, 127, 0, 0), 1, mk(S_ERROR, 0, C_FREE)},
			'{cmd_of(F_XFER_DONE, 255, '1, 256, 0, 0, 0), 1, mk(S_DONE, 0, C_FREE)},
			'{cmd_of(func_t'(3'd7), 0, 0, 1, 0, 0, 0), 1, mk(S_NOTHING, 0, C_FREE)},
			'{cmd_of(F_LOOKUP_RD, 255, '1, 1, 0, '1, 0), 1, mk(S_ALLOC, 127, C_PEND_READ)},
			'{cmd_of(F_LOOKUP_WR, 0, 0, 1, 0, 0, 0), 1, mk(S_ALLOC, 126, C_USER_FILL)},
			'{cmd_of(F_LOOKUP_WR, 255, '1, 1, 0, 5, 0), 0, '0},
			'{cmd_of(F_LOOKUP_RD, 255, '1, 1, 0, 6, 0), 0, '0},
			'{cmd_of(F_SCHEDULE, 0, 0, 1, 0, 0, 0), 0, '0},
			'{cmd_of(F_SCHEDULE, 0, 0, 1, 0, 0, 1), 0, '0},
			'{cmd_of(F_FILL_DONE, 0, 0, 1, 126, 0, 0), 0, '0},
			'{cmd_of(F_SCHEDULE, 0, 0, 1, 0, 0, 1), 0, '0},
			// Wrapping range covers both the top and the bottom block numbers.
			'{cmd_of(F_XFER_DONE, 255, '1, 2, 0, 0, 0), 0, '0},
			'{cmd_of(F_XFER_DONE, 0, '1, 2, 0, 0, 0), 0, '0},
			'{cmd_of(F_XFER_DONE, 0, 0, 0, 0, 0, 0), 0, '0},
			'{cmd_of(F_LOOKUP_WR, 0, 0, 1, 0, 9, 0), 0, '0},
			'{cmd_of(F_XFER_DONE, 0, 0, 1, 0, 0, 0), 0, '0},
			'{cmd_of(F_EVICT, 0, 0, 1, 0, 0, 0), 0, '0},
			'{cmd_of(F_EVICT, 0, 0, 1, 0, 0, 0), 0, '0},
			'{cmd_of(F_FILL_DONE, 0, 0, 1, 126, 0, 0), 0, '0}
		};
		foreach (rows[k]) begin
			r = rows[k];
			if (r.fixed) begin
				void'(predict_directory(r.cmd));
				pending_answers.push_back(r.ans);
				send_cmd(r.cmd);
			end else begin
				send_checked(r.cmd);
			end
		end
		drain();

		// Fill the directory completely, then hit the full case and evict on a miss.
		for (int i = 0; i < NENT; i++)
			send_checked(cmd_of(F_LOOKUP_RD, 1, 48'(1000 + i), 1, 0, 32'(i), 0));
		send_checked(cmd_of(F_LOOKUP_RD, 1, 48'd5000, 1, 0, 0, 0));
		for (int i = 0; i < NENT; i++)
			send_checked(cmd_of(F_SCHEDULE, 0, 0, 1, 0, 0, 1));
		send_checked(cmd_of(F_XFER_DONE, 1, 48'd1000, 256, 0, 0, 0));
		send_checked(cmd_of(F_LOOKUP_WR, 1, 48'd6000, 1, 0, 0, 0));
		drain();

		// Random phases with different idling; the pressure burst sits in the second.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 0;  recv_stall_pct = 68; end
				2: begin send_idle_pct = 68; recv_stall_pct = 0;  end
				default: begin send_idle_pct = 24; recv_stall_pct = 24; end
			endcase
			if (ph == 1) long_hold = 1'b1;
			for (int n = 0; n < 120; n++) begin
				send_checked(rand_cmd());
				if (n % 40 == 39 && $urandom_range(1)) drain();
			end
			drain();
		end

		repeat (300) @(posedge clk);
		if (mismatches == 0 && pending_answers.size() == 0) begin
			$display("block_cache_directory_core verification clean");
		end else begin
			$display("block_cache_directory_core verification failed");
		end
		$finish;
	end

endmodule

[files.f]
rtl/bcd_pkg.sv
rtl/bcd_in_if.sv
rtl/bcd_out_if.sv
rtl/bcd_ram.sv
rtl/block_cache_directory_core.sv
test/block_cache_directory_core_test.sv
